@@ rtl/core/triangle_face_normal_assert.svh @@
// Assertion macros for the face normal block
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TFN_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tfn check failed");
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tfn check failed");
`endif

@@ rtl/core/tfn_pkg.sv @@
// Package: widths, controller states and command/status types
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
    localparam int COORD_BITS = 16;
    localparam int NORMAL_BITS = 16;
    localparam int NORM_FRAC = NORMAL_BITS - 2;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
    localparam int MAG_BITS = 30;
    localparam int SUM_BITS = 62;
    localparam int ROOT_BITS = 31;
    localparam int QNUM_BITS = MAG_BITS + NORM_FRAC + 1;
    localparam int QUO_BITS = NORM_FRAC + 2;

    typedef enum logic [3:0] {
        ST_A, ST_B, ST_C, ST_MUL, ST_CROSS, ST_NORM, ST_SQ, ST_SQRT,
        ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic do_mul;
        logic do_cross;
        logic do_norm;
        logic do_sq;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic degen;
        logic sqrt_done;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

@@ rtl/core/tfn_if.sv @@
// Valid/ready channel interfaces for vertex and normal words
`timescale 1ns / 1ps
`default_nettype none
interface tfn_vert_if;
    logic valid;
    logic ready;
    logic signed [tfn_pkg::COORD_BITS-1:0] vert_x;
    logic signed [tfn_pkg::COORD_BITS-1:0] vert_y;
    logic signed [tfn_pkg::COORD_BITS-1:0] vert_z;
    modport source (output valid, vert_x, vert_y, vert_z, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface tfn_norm_if;
    logic valid;
    logic ready;
    logic signed [tfn_pkg::NORMAL_BITS-1:0] norm_x;
    logic signed [tfn_pkg::NORMAL_BITS-1:0] norm_y;
    logic signed [tfn_pkg::NORMAL_BITS-1:0] norm_z;
    logic degenerate;
    logic last_copy;
    modport source (output valid, norm_x, norm_y, norm_z, degenerate, last_copy,
        input ready);
    modport sink (input valid, norm_x, norm_y, norm_z, degenerate, last_copy,
        output ready);
endinterface
`default_nettype wire

@@ rtl/core/tfn_ctrl.sv @@
// Controller: sequences vertex capture, cross product, normalize, square root, divide, output
`timescale 1ns / 1ps
`default_nettype none
module tfn_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic                 o_last,
    output tfn_pkg::t_cmd        o_cmd,
    input  wire tfn_pkg::t_status i_status
);
    tfn_pkg::t_state r_state, n_state;
    logic [1:0] r_copy, n_copy;
    logic acc;

    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfn_pkg::ST_A;
            r_copy <= '0;
        end else begin
            r_state <= n_state;
            r_copy <= n_copy;
        end
    end

    always_comb begin
        n_state = r_state;
        n_copy = r_copy;
        unique case (r_state)
            tfn_pkg::ST_A: if (acc) n_state = tfn_pkg::ST_B;
            tfn_pkg::ST_B: if (acc) n_state = tfn_pkg::ST_C;
            tfn_pkg::ST_C: if (acc) n_state = tfn_pkg::ST_MUL;
            tfn_pkg::ST_MUL: n_state = tfn_pkg::ST_CROSS;
            tfn_pkg::ST_CROSS: n_state = tfn_pkg::ST_NORM;
            tfn_pkg::ST_NORM: begin
                if (i_status.degen) begin
                    n_state = tfn_pkg::ST_OUT;
                    n_copy = '0;
                end else if (i_status.norm_done) begin
                    n_state = tfn_pkg::ST_SQ;
                end
            end
            tfn_pkg::ST_SQ: n_state = tfn_pkg::ST_SQRT;
            tfn_pkg::ST_SQRT: if (i_status.sqrt_done) n_state = tfn_pkg::ST_DIV;
            tfn_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = tfn_pkg::ST_OUT;
                    n_copy = '0;
                end
            end
            tfn_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_copy = r_copy + 2'd1;
                    if (r_copy == 2'd2) n_state = tfn_pkg::ST_A;
                end
            end
            default: n_state = tfn_pkg::ST_A;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_last = (r_copy == 2'd2);
        unique case (r_state)
            tfn_pkg::ST_A: begin
                o_in_ready = 1'b1;
                o_cmd.load_a = acc;
            end
            tfn_pkg::ST_B: begin
                o_in_ready = 1'b1;
                o_cmd.load_b = acc;
            end
            tfn_pkg::ST_C: begin
                o_in_ready = 1'b1;
                o_cmd.load_c = acc;
            end
            tfn_pkg::ST_MUL: o_cmd.do_mul = 1'b1;
            tfn_pkg::ST_CROSS: o_cmd.do_cross = 1'b1;
            tfn_pkg::ST_NORM: o_cmd.do_norm = 1'b1;
            tfn_pkg::ST_SQ: begin
                o_cmd.do_sq = 1'b1;
                o_cmd.sqrt_start = 1'b1;
            end
            tfn_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.div_start = i_status.sqrt_done;
            end
            tfn_pkg::ST_DIV: o_cmd.div_step = 1'b1;
            tfn_pkg::ST_OUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/tfn_dp.sv @@
// Datapath: edges, cross product, normalize shift, sqrt and divide
`timescale 1ns / 1ps
`default_nettype none
module tfn_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire tfn_pkg::t_cmd                           i_cmd,
    output tfn_pkg::t_status                             o_status,
    input  wire logic signed [tfn_pkg::COORD_BITS-1:0]  i_vx,
    input  wire logic signed [tfn_pkg::COORD_BITS-1:0]  i_vy,
    input  wire logic signed [tfn_pkg::COORD_BITS-1:0]  i_vz,
    output logic signed [tfn_pkg::NORMAL_BITS-1:0]      o_nx,
    output logic signed [tfn_pkg::NORMAL_BITS-1:0]      o_ny,
    output logic signed [tfn_pkg::NORMAL_BITS-1:0]      o_nz,
    output logic                                        o_degen
);
    localparam int DB = tfn_pkg::DIFF_BITS;
    localparam int CB = tfn_pkg::CROSS_BITS;
    localparam int MB = tfn_pkg::MAG_BITS;
    localparam int PB = 2 * DB;
    localparam int MW = (CB > MB) ? CB : MB;
    localparam int QN = tfn_pkg::QNUM_BITS;
    localparam int QB = tfn_pkg::QUO_BITS;
    localparam int RB = tfn_pkg::ROOT_BITS;
    localparam int SB = tfn_pkg::SUM_BITS;

    logic signed [tfn_pkg::COORD_BITS-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [DB-1:0] r_e1 [3];
    logic signed [DB-1:0] r_e2 [3];
    logic signed [PB-1:0] r_p [6];
    logic [2:0] r_neg;
    logic [MW-1:0] r_mag [3];
    logic [SB-1:0] r_rem;
    logic [RB-1:0] r_root;
    logic [4:0] r_scnt;
    logic [MB-1:0] r_m [3];
    logic [QN-1:0] r_num [3];
    logic [QB-1:0] r_quo [3];
    logic [QN:0] r_drem [3];
    logic [5:0] r_dcnt;
    logic r_degen;
    logic signed [CB-1:0] cr [3];
    logic [MW-1:0] maxm;
    logic [SB:0] trial;
    logic [RB:0] den;

    always_comb begin
        cr[0] = CB'(r_p[0]) - CB'(r_p[1]);
        cr[1] = CB'(r_p[2]) - CB'(r_p[3]);
        cr[2] = CB'(r_p[4]) - CB'(r_p[5]);
        maxm = r_mag[0] | r_mag[1] | r_mag[2];
        trial = {1'b0, r_rem} - ({{(SB-RB-1){1'b0}}, r_root, 2'b01} << (2 * r_scnt));
        den = {1'b0, r_root};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_ax <= i_vx; r_ay <= i_vy; r_az <= i_vz;
        end
        if (i_cmd.load_b) begin
            r_bx <= i_vx; r_by <= i_vy; r_bz <= i_vz;
        end
        if (i_cmd.load_c) begin
            r_e1[0] <= DB'(r_bx) - DB'(r_ax);
            r_e1[1] <= DB'(r_by) - DB'(r_ay);
            r_e1[2] <= DB'(r_bz) - DB'(r_az);
            r_e2[0] <= DB'(i_vx) - DB'(r_ax);
            r_e2[1] <= DB'(i_vy) - DB'(r_ay);
            r_e2[2] <= DB'(i_vz) - DB'(r_az);
        end
        if (i_cmd.do_mul) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
        end
        if (i_cmd.do_cross) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= cr[i][CB-1];
                r_mag[i] <= MW'(cr[i][CB-1] ? -cr[i] : cr[i]);
            end
        end
        if (i_cmd.do_norm) begin
            r_degen <= (maxm == '0);
            if (maxm >= (MW'(1) << MB)) begin
                for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
            end else if (maxm < (MW'(1) << (MB - 1)) && maxm != '0) begin
                for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
            end
        end
        if (i_cmd.do_sq) begin
            for (int i = 0; i < 3; i++) r_m[i] <= r_mag[i][MB-1:0];
            r_rem <= SB'(r_mag[0][MB-1:0] * r_mag[0][MB-1:0])
                   + SB'(r_mag[1][MB-1:0] * r_mag[1][MB-1:0])
                   + SB'(r_mag[2][MB-1:0] * r_mag[2][MB-1:0]);
            r_root <= '0;
            r_scnt <= 5'(RB - 1);
        end
        if (i_cmd.sqrt_step) begin
            if (!trial[SB]) begin
                r_rem <= trial[SB-1:0];
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_root <= {r_root[RB-2:0], 1'b0};
            end
            r_scnt <= r_scnt - 5'd1;
        end
        if (i_cmd.div_start) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= (QN'(r_m[i]) << tfn_pkg::NORM_FRAC) + QN'(r_root);
                r_drem[i] <= '0;
                r_quo[i] <= '0;
            end
            r_dcnt <= 6'(QN);
        end
        if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                logic [QN:0] sh;
                sh = {r_drem[i][QN-1:0], r_num[i][QN-1]};
                r_num[i] <= r_num[i] << 1;
                if (sh >= (QN+1)'(den)) begin
                    r_drem[i] <= sh - (QN+1)'(den);
                    r_quo[i] <= {r_quo[i][QB-2:0], 1'b1};
                end else begin
                    r_drem[i] <= sh;
                    r_quo[i] <= {r_quo[i][QB-2:0], 1'b0};
                end
            end
            r_dcnt <= r_dcnt - 6'd1;
        end
        if (!i_rst_n) begin
            r_scnt <= '0;
            r_dcnt <= '0;
        end
    end

    always_comb begin
        o_status.norm_done = (maxm < (MW'(1) << MB)) && (maxm >= (MW'(1) << (MB - 1)));
        o_status.degen = (maxm == '0);
        o_status.sqrt_done = (r_scnt == '0) && i_cmd.sqrt_step;
        o_status.div_done = (r_dcnt == 6'd1) && i_cmd.div_step;
        o_degen = r_degen;
        o_nx = r_degen ? '0 : (r_neg[0] ? -tfn_pkg::NORMAL_BITS'(r_quo[0])
                                        : tfn_pkg::NORMAL_BITS'(r_quo[0]));
        o_ny = r_degen ? '0 : (r_neg[1] ? -tfn_pkg::NORMAL_BITS'(r_quo[1])
                                        : tfn_pkg::NORMAL_BITS'(r_quo[1]));
        o_nz = r_degen ? '0 : (r_neg[2] ? -tfn_pkg::NORMAL_BITS'(r_quo[2])
                                        : tfn_pkg::NORMAL_BITS'(r_quo[2]));
    end
endmodule
`default_nettype wire

@@ rtl/core/triangle_face_normal.sv @@
// Top level: face normal unit, controller plus datapath
// Flow: three vertex words are accepted, then the normal is computed (0 to 29 normalize
// shifts, 31 square root steps, 45 divide steps) and sent as three copies of one word;
// a degenerate triangle skips the square root and divide and outputs a zero normal.
// No new vertex is accepted until the last copy of the normal has been taken.
// Reset: synchronous active low, clears the controller; vertex store undefined.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    tfn_vert_if.sink   i_vert,
    tfn_norm_if.source o_norm
);
    tfn_pkg::t_cmd cmd;
    tfn_pkg::t_status status;

    tfn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_vert.valid), .o_in_ready(i_vert.ready),
        .o_out_valid(o_norm.valid), .i_out_ready(o_norm.ready),
        .o_last(o_norm.last_copy), .o_cmd(cmd), .i_status(status)
    );

    tfn_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_vx(i_vert.vert_x), .i_vy(i_vert.vert_y), .i_vz(i_vert.vert_z),
        .o_nx(o_norm.norm_x), .o_ny(o_norm.norm_y), .o_nz(o_norm.norm_z),
        .o_degen(o_norm.degenerate)
    );
endmodule
`default_nettype wire

@@ rtl/core/tfn_checker.sv @@
// Port checker for the face normal unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_face_normal_assert.svh"
module tfn_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic last_copy,
    input wire logic degenerate,
    input wire logic [tfn_pkg::NORMAL_BITS-1:0] nx
);
    `TFN_ASSERT_IMPL(a_excl, i_clk, i_rst_n, out_valid, !in_ready)
    `TFN_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, out_valid && degenerate, nx == '0)
    `TFN_ASSERT_NEXT(a_last_end, i_clk, i_rst_n, out_valid && out_ready && last_copy,
        !out_valid)
    `TFN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready,
        out_valid && $stable(nx))
endmodule

bind triangle_face_normal tfn_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(i_vert.ready),
    .out_valid(o_norm.valid), .out_ready(o_norm.ready),
    .last_copy(o_norm.last_copy), .degenerate(o_norm.degenerate),
    .nx(o_norm.norm_x)
);
`default_nettype wire
